// File: rtl/acl_pkg.sv
// Shared types, constants and the saturating add for the autocorrelation lag core.
package acl_pkg;

   localparam int NUM_LAGS_DEF = 14;
   localparam int SAMPLE_W = 24;
   localparam int PROD_W = 48;
   localparam int SUM_W = 64;
   localparam int LAG_IDX_W = 4;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic block_end;
   } req_type;

   typedef struct packed {
      logic [LAG_IDX_W-1:0] lag_index;
      logic signed [SUM_W-1:0] lag_sum;
      logic run_last;
   } rsp_type;

   typedef struct packed {
      logic take;
      logic take_end;
      logic acc_fire;
      logic acc_end;
      logic dump_load;
      logic dump_shift;
   } ctl_type;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [PROD_W-1:0] b
   );
      logic signed [SUM_W:0] wide;
      logic signed [SUM_W-1:0] res;
      wide = {a[SUM_W-1], a} + {{(SUM_W-PROD_W+1){b[PROD_W-1]}}, b};
      if (wide[SUM_W] != wide[SUM_W-1]) begin
         res = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         res = wide[SUM_W-1:0];
      end
      return res;
   endfunction

endpackage

// File: rtl/autocorrelation_lags_core.sv
// Top level of the autocorrelation lag core: a row of lag cells and the item control.
//
// Usage: samples enter on the req_ channel, one item per cycle unless stalled. Each
// item carries a signed 24-bit sample and a block_end flag. Every lag cell multiplies
// the new sample with its delayed sample and adds the product to its saturating
// 64-bit sum. When the item flagged block_end has been summed, all NUM_LAGS sums move
// at once into an output shift chain and the sums and delay line are cleared.
// The rsp_ channel then carries NUM_LAGS items, lag 0 first, one per cycle while
// rsp_stall is low; run_last marks the item of the highest lag.
// Throughput is one sample per cycle while req_stall is low. The first result of a
// block is valid once its last sample has passed the product stage and the sums have
// been loaded into the output chain. A further block end waits in the product stage,
// holding req_stall high, until the output chain of the previous block has drained.
// A stalled receiver stops the output chain; samples flow on until a block end waits.
// Reset is synchronous and clears the sums, the delay line and all valid state.
module autocorrelation_lags_core #(
   parameter int NUM_LAGS = acl_pkg::NUM_LAGS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  acl_pkg::req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output acl_pkg::rsp_type rsp_payload
);
   import acl_pkg::*;

   localparam int IDX_W = (NUM_LAGS > 1) ? $clog2(NUM_LAGS) : 1;

   logic valid_a_ff;
   logic end_a_ff;
   logic busy_ff;
   logic [IDX_W-1:0] idx_ff;
   logic stall_b;
   logic rsp_take;
   logic idx_last;
   ctl_type ctl;

   logic signed [SAMPLE_W-1:0] tap_w [NUM_LAGS+1];
   logic signed [SUM_W-1:0] dump_w [NUM_LAGS+1];

   assign stall_b = valid_a_ff && end_a_ff && busy_ff;
   assign req_stall = stall_b;
   assign rsp_take = busy_ff && !rsp_stall;
   assign idx_last = (idx_ff == IDX_W'(NUM_LAGS - 1));

   always_comb begin
      ctl.take = req_valid && !stall_b;
      ctl.take_end = req_payload.block_end;
      ctl.acc_fire = valid_a_ff && !stall_b;
      ctl.acc_end = end_a_ff;
      ctl.dump_load = valid_a_ff && end_a_ff && !busy_ff;
      ctl.dump_shift = rsp_take;
   end

   assign tap_w[0] = req_payload.sample;
   assign dump_w[NUM_LAGS] = '0;

   for (genvar k = 0; k < NUM_LAGS; k++) begin : g_cell
      acl_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .x_in    (req_payload.sample),
         .tap_in  (tap_w[k]),
         .tap_out (tap_w[k+1]),
         .dump_in (dump_w[k+1]),
         .dump_out(dump_w[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         end_a_ff <= 1'b0;
         busy_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (!stall_b) begin
            valid_a_ff <= ctl.take;
            end_a_ff <= req_payload.block_end;
         end
         if (ctl.dump_load) begin
            busy_ff <= 1'b1;
            idx_ff <= '0;
         end else if (rsp_take) begin
            if (idx_last) begin
               busy_ff <= 1'b0;
               idx_ff <= '0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   assign rsp_valid = busy_ff;

   always_comb begin
      rsp_payload.lag_index = LAG_IDX_W'(idx_ff);
      rsp_payload.lag_sum = dump_w[0];
      rsp_payload.run_last = idx_last;
   end

endmodule

// File: rtl/acl_cell.sv
// One lag cell: delay tap, product register, saturating accumulator and output shift stage.
module acl_cell (
   input  logic clock,
   input  logic reset,
   input  acl_pkg::ctl_type ctl,
   input  logic signed [acl_pkg::SAMPLE_W-1:0] x_in,
   input  logic signed [acl_pkg::SAMPLE_W-1:0] tap_in,
   output logic signed [acl_pkg::SAMPLE_W-1:0] tap_out,
   input  logic signed [acl_pkg::SUM_W-1:0] dump_in,
   output logic signed [acl_pkg::SUM_W-1:0] dump_out
);
   import acl_pkg::*;

   logic signed [SAMPLE_W-1:0] tap_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0] acc_ff;
   logic signed [SUM_W-1:0] dump_ff;
   logic signed [SUM_W-1:0] sum_in;

   assign sum_in = sat_add(acc_ff, prod_ff);
   assign tap_out = tap_ff;
   assign dump_out = dump_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (ctl.take) begin
            tap_ff <= ctl.take_end ? '0 : tap_in;
         end
         if (ctl.acc_fire) begin
            acc_ff <= ctl.acc_end ? '0 : sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take) begin
         prod_ff <= x_in * tap_in;
      end
      if (ctl.dump_load) begin
         dump_ff <= sum_in;
      end else if (ctl.dump_shift) begin
         dump_ff <= dump_in;
      end
   end

endmodule
